### hw/rtl/nlcm_pkg.sv
// Shared constants, codes and types of the node lease coverage monitor.
`timescale 1ns / 1ps
`default_nettype none

package nlcm_pkg;

  localparam int NODES        = 32;
  localparam int ADDR_W       = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int MAX_PROBLEMS = 32;
  localparam int CNT_W        = $clog2(MAX_PROBLEMS + 1);
  localparam int TIME_W       = 32;

  localparam logic [31:0] LEASE_RESET = 32'd60;

  localparam logic [2:0] KIND_REQUIRE   = 3'd0;
  localparam logic [2:0] KIND_FORGET    = 3'd1;
  localparam logic [2:0] KIND_OBSERVE   = 3'd2;
  localparam logic [2:0] KIND_SET_FAULT = 3'd3;
  localparam logic [2:0] KIND_QUERY     = 3'd4;

  localparam logic [1:0] RSN_NEVER_SEEN = 2'd0;
  localparam logic [1:0] RSN_EXPIRED    = 2'd1;
  localparam logic [1:0] RSN_FAULT      = 2'd2;
  localparam logic [1:0] RSN_NONE       = 2'd3;

  localparam logic [1:0] OVR_COVERED = 2'd0;
  localparam logic [1:0] OVR_UNKNOWN = 2'd1;
  localparam logic [1:0] OVR_FAULT   = 2'd2;

  typedef struct packed {
    logic              req;
    logic              fault;
    logic [TIME_W-1:0] contact;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### hw/rtl/nlcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nlcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/nlcm_check.sv
// Per-node health check: never seen, lease expired, sensor fault or healthy.
`timescale 1ns / 1ps
`default_nettype none

module nlcm_check (
  input  wire nlcm_pkg::entry_t              entry,
  input  wire logic [nlcm_pkg::TIME_W-1:0]   now,
  input  wire logic [nlcm_pkg::TIME_W-1:0]   lease,
  output logic      [1:0]                    reason
);

  logic [nlcm_pkg::TIME_W-1:0] age;

  assign age = now - entry.contact;

  always_comb begin
    if (entry.contact == '0) begin
      reason = nlcm_pkg::RSN_NEVER_SEEN;
    end else if ((now > entry.contact) && (age > lease)) begin
      reason = nlcm_pkg::RSN_EXPIRED;
    end else if (entry.fault) begin
      reason = nlcm_pkg::RSN_FAULT;
    end else begin
      reason = nlcm_pkg::RSN_NONE;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/node_lease_coverage_monitor.sv
// Top level of the node lease coverage monitor: node table, update and query sequencer.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | kind, node, event_time, fault_flag
//   out_    | output    | out_valid/out_stall | problem_node, reason, overall, last
//   cfg_    | input     | cfg_wr_en           | wr_data (lease period)
//
// Update kinds read the table entry, then write it back.
// A query makes one table read per node through the single read port, then
// emits the final item.
// Reset is synchronous; per-node valid bits make the whole table read as zero.
// An output stall holds the walk on the pending problem node.
`timescale 1ns / 1ps
`default_nettype none

module node_lease_coverage_monitor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [4:0]  in_node,
  input  wire logic [31:0] in_event_time,
  input  wire logic        in_fault_flag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_problem_node,
  output logic [1:0]       out_reason,
  output logic [1:0]       out_overall,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_QRUN = 2'd2;
  localparam logic [1:0] ST_QFIN = 2'd3;

  localparam int AW = nlcm_pkg::ADDR_W;
  localparam int CW = nlcm_pkg::CNT_W;

  logic [1:0]                  state_r, state_nxt;
  logic [2:0]                  kind_r, kind_nxt;
  logic [AW-1:0]               node_r, node_nxt;
  logic [nlcm_pkg::TIME_W-1:0] time_r, time_nxt;
  logic                        flag_r, flag_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        found_r, found_nxt;
  logic [1:0]                  overall_r, overall_nxt;
  logic [nlcm_pkg::NODES-1:0]  vld_r, vld_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [31:0]                 lease_r, lease_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [4:0]                  out_node_r, out_node_nxt;
  logic [1:0]                  out_reason_r, out_reason_nxt;
  logic [1:0]                  out_overall_r, out_overall_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  nlcm_pkg::entry_t            ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [nlcm_pkg::ENTRY_W-1:0] ram_rdata;

  nlcm_pkg::entry_t            entry_rd;
  logic [1:0]                  chk_reason;
  logic                        problem;
  logic                        emit;
  logic                        out_free;
  logic                        in_range;

  nlcm_ram #(
    .WIDTH (nlcm_pkg::ENTRY_W),
    .DEPTH (nlcm_pkg::NODES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign entry_rd = rd_vld_r ? nlcm_pkg::entry_t'(ram_rdata) : '0;

  nlcm_check u_check (
    .entry  (entry_rd),
    .now    (time_r),
    .lease  (lease_r),
    .reason (chk_reason)
  );

  assign problem  = entry_rd.req && (chk_reason != nlcm_pkg::RSN_NONE);
  assign emit     = problem && (cnt_r < CW'(nlcm_pkg::MAX_PROBLEMS));
  assign out_free = !out_valid_r || !out_stall;
  assign in_range = 32'(in_node) < 32'(nlcm_pkg::NODES);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    node_nxt        = node_r;
    time_nxt        = time_r;
    flag_nxt        = flag_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    overall_nxt     = overall_r;
    vld_nxt         = vld_r;
    rd_vld_nxt      = rd_vld_r;
    lease_nxt       = cfg_wr_en ? cfg_wr_data : lease_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_node_nxt    = out_node_r;
    out_reason_nxt  = out_reason_r;
    out_overall_nxt = out_overall_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = node_r;
    ram_wdata       = entry_rd;
    ram_re          = 1'b0;
    ram_raddr       = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          node_nxt = AW'(in_node);
          time_nxt = in_event_time;
          flag_nxt = in_fault_flag;
          case (in_kind)
            nlcm_pkg::KIND_REQUIRE, nlcm_pkg::KIND_FORGET,
            nlcm_pkg::KIND_OBSERVE, nlcm_pkg::KIND_SET_FAULT: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_node);
                state_nxt = ST_UPD;
              end
            end
            nlcm_pkg::KIND_QUERY: begin
              ram_re      = 1'b1;
              ram_raddr   = '0;
              idx_nxt     = '0;
              cnt_nxt     = '0;
              found_nxt   = 1'b0;
              overall_nxt = nlcm_pkg::OVR_COVERED;
              state_nxt   = ST_QRUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_UPD: begin
        ram_we = 1'b1;
        case (kind_r)
          nlcm_pkg::KIND_REQUIRE:   ram_wdata.req     = 1'b1;
          nlcm_pkg::KIND_FORGET:    ram_wdata         = '0;
          nlcm_pkg::KIND_OBSERVE:   ram_wdata.contact = time_r;
          nlcm_pkg::KIND_SET_FAULT: ram_wdata.fault   = flag_r;
          default:                  ram_we            = 1'b0;
        endcase
        vld_nxt[node_r] = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_QRUN: begin
        if (!emit || out_free) begin
          if (problem && !found_r) begin
            found_nxt   = 1'b1;
            overall_nxt = (chk_reason == nlcm_pkg::RSN_FAULT) ?
                          nlcm_pkg::OVR_FAULT : nlcm_pkg::OVR_UNKNOWN;
          end
          if (emit) begin
            cnt_nxt         = cnt_r + CW'(1);
            out_valid_nxt   = 1'b1;
            out_node_nxt    = 5'(idx_r);
            out_reason_nxt  = chk_reason;
            out_overall_nxt = nlcm_pkg::OVR_COVERED;
            out_last_nxt    = 1'b0;
          end
          if (idx_r == AW'(nlcm_pkg::NODES - 1)) begin
            state_nxt = ST_QFIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + AW'(1);
            idx_nxt   = idx_r + AW'(1);
          end
        end
      end
      ST_QFIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_node_nxt    = '0;
          out_reason_nxt  = nlcm_pkg::RSN_NONE;
          out_overall_nxt = overall_r;
          out_last_nxt    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ram_re) begin
      rd_vld_nxt = vld_r[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      lease_r     <= nlcm_pkg::LEASE_RESET;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      lease_r     <= lease_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    node_r        <= node_nxt;
    time_r        <= time_nxt;
    flag_r        <= flag_nxt;
    overall_r     <= overall_nxt;
    out_node_r    <= out_node_nxt;
    out_reason_r  <= out_reason_nxt;
    out_overall_r <= out_overall_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_problem_node = out_node_r;
  assign out_reason       = out_reason_r;
  assign out_overall      = out_overall_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire
